FILE: hdl/srt_pkg.sv
// Package for the sorted record table: widths, status codes, record type, helpers.
// No dependencies.
package srt_pkg;
    localparam int Capacity = 8;
    localparam int IdxW = $clog2(Capacity);
    localparam int CntW = $clog2(Capacity + 1);
    localparam int StrW = 152;

    localparam logic [1:0] FUNC_LIST = 2'd0;
    localparam logic [1:0] FUNC_ADD  = 2'd1;
    localparam logic [1:0] FUNC_REM  = 2'd2;
    localparam logic [1:0] FUNC_GET  = 2'd3;

    localparam logic [3:0] ST_ADDED     = 4'd0;
    localparam logic [3:0] ST_DUP       = 4'd1;
    localparam logic [3:0] ST_FULL      = 4'd2;
    localparam logic [3:0] ST_REMOVED   = 4'd3;
    localparam logic [3:0] ST_ABSENT    = 4'd4;
    localparam logic [3:0] ST_EMPTY     = 4'd5;
    localparam logic [3:0] ST_FOUND     = 4'd6;
    localparam logic [3:0] ST_NOTFOUND  = 4'd7;
    localparam logic [3:0] ST_ENTRY     = 4'd8;
    localparam logic [3:0] ST_LISTEMPTY = 4'd9;

    typedef struct packed {
        logic signed [31:0] id;
        logic [StrW-1:0]    name;
        logic [StrW-1:0]    firm;
    } t_rec;

    // per-cell command from the controller
    typedef struct packed {
        logic          ins;     // insert at pos, shift up at and above
        logic          del;     // delete at pos, shift down above
        logic [IdxW:0] pos;
    } t_cmd;

    // clear bytes after the first zero
    function automatic logic [StrW-1:0] clean_str(input logic [StrW-1:0] s);
        logic [StrW-1:0] r;
        logic ended;
        r = '0;
        ended = 1'b0;
        for (int i = 0; i < StrW / 8; i++) begin
            if (s[i*8 +: 8] == 8'd0) ended = 1'b1;
            r[i*8 +: 8] = ended ? 8'd0 : s[i*8 +: 8];
        end
        return r;
    endfunction

    function automatic logic [StrW-1:0] fold_str(input logic [StrW-1:0] s);
        logic [StrW-1:0] r;
        r = s;
        for (int i = 0; i < StrW / 8; i++) begin
            if (s[i*8 +: 8] >= 8'h61 && s[i*8 +: 8] <= 8'h7a)
                r[i*8 +: 8] = s[i*8 +: 8] - 8'h20;
        end
        return r;
    endfunction
endpackage

FILE: hdl/srt_cell.sv
// One table slot: holds a record and shifts with its neighbors.
// Depends on srt_pkg.
module srt_cell (
    input  logic            i_clk,
    input  logic [srt_pkg::IdxW:0] i_idx,
    input  srt_pkg::t_cmd   i_cmd,
    input  srt_pkg::t_rec   i_new,
    input  srt_pkg::t_rec   i_below,
    input  srt_pkg::t_rec   i_above,
    input  logic [srt_pkg::StrW-1:0] i_target,
    output srt_pkg::t_rec   o_rec,
    output logic            o_match,
    output logic            o_less,
    output logic            o_equal,
    input  logic signed [31:0] i_key
);
    srt_pkg::t_rec r_rec;
    assign o_rec = r_rec;

    // compare flags; only meaningful for occupied slots
    assign o_match = (srt_pkg::fold_str(r_rec.name) == i_target);
    assign o_less  = (r_rec.id < i_key);
    assign o_equal = (r_rec.id == i_key);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (i_idx == i_cmd.pos) r_rec <= i_new;
            else if (i_idx > i_cmd.pos) r_rec <= i_below;
        end else if (i_cmd.del) begin
            if (i_idx >= i_cmd.pos) r_rec <= i_above;
        end
    end
endmodule

FILE: hdl/sorted_record_table_top.sv
// Top level: controller and the row of record cells.
// Depends on srt_pkg and srt_cell.
//
// channel | dir | tdata                              | tuser | tlast
// s_axis  | in  | card_id, name 0..2, company 0..2   | func  | -
// m_axis  | out | out_id, out_name0..2, out_company0..2 | status | last
//
// Add, remove, get: accept, compute, then one result.
// List: one result per entry from the cell row, or one list-empty result.
// Reset clears only the entry count and control; cells hold undefined data.
// Input is held off while a result waits; stalls on m_axis hold the result.
module sorted_record_table_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] card_id, [95:32] name_word0, [159:96] name_word1, [183:160] name_word2,
    // [247:184] company_word0, [311:248] company_word1, [335:312] company_word2
    input  logic [335:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,   // [1:0] func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] out_id, [95:32] out_name0, [159:96] out_name1, [183:160] out_name2,
    // [247:184] out_company0, [311:248] out_company1, [335:312] out_company2
    output logic [335:0] m_axis_tdata,
    output logic [3:0]   m_axis_tuser,   // [3:0] status
    output logic         m_axis_tlast
);
    localparam int N = srt_pkg::Capacity;
    localparam int IW = srt_pkg::IdxW;
    localparam int CW = srt_pkg::CntW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;
    localparam logic [1:0] S_LIST = 2'd3;

    logic [1:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [1:0]    r_func;
    srt_pkg::t_rec r_in;
    logic [srt_pkg::StrW-1:0] r_target;
    logic [IW:0]   r_lidx;
    logic          r_ovalid;
    srt_pkg::t_rec r_orec;
    logic [3:0]    r_ostat;
    logic          r_olast;

    srt_pkg::t_rec  w_rec [N];
    logic [N-1:0]   w_match, w_less, w_equal;
    srt_pkg::t_cmd  w_cmd;

    // cell row
    for (genvar g = 0; g < N; g++) begin : g_cell
        srt_pkg::t_rec w_below, w_above;
        if (g == 0) begin : g_lo
            assign w_below = r_in;
        end else begin : g_lo
            assign w_below = w_rec[g-1];
        end
        if (g == N - 1) begin : g_hi
            assign w_above = r_in;
        end else begin : g_hi
            assign w_above = w_rec[g+1];
        end
        srt_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   ((IW+1)'(g)),
            .i_cmd   (w_cmd),
            .i_new   (r_in),
            .i_below (w_below),
            .i_above (w_above),
            .i_target(r_target),
            .o_rec   (w_rec[g]),
            .o_match (w_match[g]),
            .o_less  (w_less[g]),
            .o_equal (w_equal[g]),
            .i_key   (r_in.id)
        );
    end

    // search results over occupied cells
    logic [N-1:0] w_occ;
    logic         w_dup, w_hit;
    logic [IW:0]  w_pos, w_hidx;
    always_comb begin
        w_dup = 1'b0;
        w_hit = 1'b0;
        w_pos = '0;
        w_hidx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            w_occ[i] = ((CW+1)'(i) < {1'b0, r_cnt});
            if (w_occ[i] && w_equal[i]) w_dup = 1'b1;
            if (w_occ[i] && w_less[i]) w_pos = w_pos + 1'b1;
            if (w_occ[i] && w_match[i]) begin
                w_hit = 1'b1;
                w_hidx = (IW+1)'(i);
            end
        end
    end

    logic w_full, w_empty;
    assign w_full  = ({1'b0, r_cnt} >= (CW+1)'(N));
    assign w_empty = (r_cnt == '0);

    always_comb begin
        w_cmd.ins = (r_state == S_EXEC) && (r_func == srt_pkg::FUNC_ADD) && !w_full && !w_dup;
        w_cmd.del = (r_state == S_EXEC) && (r_func == srt_pkg::FUNC_REM) && !w_empty && w_hit;
        w_cmd.pos = w_cmd.ins ? w_pos : w_hidx;
    end

    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_orec.firm, r_orec.name, r_orec.id};
    assign m_axis_tuser  = r_ostat;
    assign m_axis_tlast  = r_olast;

    logic w_otake;
    assign w_otake = !r_ovalid || m_axis_tready;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_lidx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_olast <= 1'b1;
                    case (r_func)
                        srt_pkg::FUNC_LIST: begin
                            if (w_empty) begin
                                r_ostat  <= srt_pkg::ST_LISTEMPTY;
                                r_orec   <= '0;
                                r_ovalid <= 1'b1;
                                r_state  <= S_OUT;
                            end else begin
                                r_lidx   <= '0;
                                r_state  <= S_LIST;
                            end
                        end
                        srt_pkg::FUNC_ADD: begin
                            r_orec   <= '0;
                            r_ovalid <= 1'b1;
                            r_state  <= S_OUT;
                            if (w_full) r_ostat <= srt_pkg::ST_FULL;
                            else if (w_dup) r_ostat <= srt_pkg::ST_DUP;
                            else begin
                                r_ostat <= srt_pkg::ST_ADDED;
                                r_cnt   <= r_cnt + 1'b1;
                            end
                        end
                        srt_pkg::FUNC_REM: begin
                            r_ovalid <= 1'b1;
                            r_state  <= S_OUT;
                            if (w_empty) begin
                                r_ostat <= srt_pkg::ST_EMPTY;
                                r_orec  <= '0;
                            end else if (!w_hit) begin
                                r_ostat <= srt_pkg::ST_ABSENT;
                                r_orec  <= '0;
                            end else begin
                                r_ostat <= srt_pkg::ST_REMOVED;
                                r_orec  <= w_rec[w_hidx[IW-1:0]];
                                r_cnt   <= r_cnt - 1'b1;
                            end
                        end
                        default: begin
                            r_ovalid <= 1'b1;
                            r_state  <= S_OUT;
                            if (w_hit) begin
                                r_ostat <= srt_pkg::ST_FOUND;
                                r_orec  <= w_rec[w_hidx[IW-1:0]];
                            end else begin
                                r_ostat <= srt_pkg::ST_NOTFOUND;
                                r_orec  <= '0;
                            end
                        end
                    endcase
                end
                S_OUT: begin
                    if (r_ovalid && m_axis_tready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                S_LIST: begin
                    if (w_otake) begin
                        if (r_lidx == r_cnt) begin
                            // final entry taken (or none pending)
                            r_ovalid <= 1'b0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_ovalid <= 1'b1;
                            r_orec   <= w_rec[r_lidx[IW-1:0]];
                            r_ostat  <= srt_pkg::ST_ENTRY;
                            r_olast  <= (r_lidx + 1'b1 == r_cnt);
                            r_lidx   <= r_lidx + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // input capture; strings cleaned once on the way in
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_func      <= s_axis_tuser;
            r_in.id     <= s_axis_tdata[31:0];
            r_in.name   <= srt_pkg::clean_str(s_axis_tdata[183:32]);
            r_in.firm   <= srt_pkg::clean_str(s_axis_tdata[335:184]);
            r_target    <= srt_pkg::fold_str(srt_pkg::clean_str(s_axis_tdata[183:32]));
        end
    end
endmodule

FILE: tb/sorted_record_table_top_tb.sv
// Testbench for sorted_record_table_top: drives record add/remove/get/list
// transfers and checks every result against a table model in a scoreboard class.
// Depends on srt_pkg and the RTL of sorted_record_table_top.
module sorted_record_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [3:0]   status;
        logic [335:0] data;
        logic         last;
    } t_result;

    // Table model and queue of expected results
    class record_scoreboard;
        logic signed [31:0]       keys[srt_pkg::Capacity];
        logic [srt_pkg::StrW-1:0] names[srt_pkg::Capacity];
        logic [srt_pkg::StrW-1:0] firms[srt_pkg::Capacity];
        int                 count;
        t_result            pending[$];
        int                 errors;

        function new();
            count = 0;
            errors = 0;
        endfunction

        function logic [srt_pkg::StrW-1:0] trim(input logic [srt_pkg::StrW-1:0] s);
            logic [srt_pkg::StrW-1:0] r;
            logic ended;
            r = '0;
            ended = 1'b0;
            for (int i = 0; i < srt_pkg::StrW / 8; i++) begin
                if (s[i*8 +: 8] == 8'd0) ended = 1'b1;
                if (!ended) r[i*8 +: 8] = s[i*8 +: 8];
            end
            return r;
        endfunction

        function logic [srt_pkg::StrW-1:0] upcase(input logic [srt_pkg::StrW-1:0] s);
            logic [srt_pkg::StrW-1:0] r;
            r = s;
            for (int i = 0; i < srt_pkg::StrW / 8; i++)
                if (s[i*8 +: 8] >= "a" && s[i*8 +: 8] <= "z") r[i*8 +: 8] = s[i*8 +: 8] - 8'd32;
            return r;
        endfunction

        function void push(input logic [3:0] st, input int idx, input logic lst);
            t_result r;
            r.status = st;
            r.data = '0;
            if (idx >= 0) r.data = {firms[idx], names[idx], keys[idx]};
            r.last = lst;
            pending.push_back(r);
        endfunction

        function int find_name(input logic [srt_pkg::StrW-1:0] nm);
            logic [srt_pkg::StrW-1:0] t;
            t = upcase(trim(nm));
            for (int i = 0; i < count; i++)
                if (upcase(trim(names[i])) == t) return i;
            return -1;
        endfunction

        // Note an accepted input transfer and queue its results
        function void note_op(input logic [1:0] fn, input logic [335:0] d);
            logic signed [31:0] key;
            logic [srt_pkg::StrW-1:0] nm;
            int pos;
            int hit;
            key = d[31:0];
            nm = d[183:32];
            case (fn)
                srt_pkg::FUNC_LIST: begin
                    if (count == 0) push(srt_pkg::ST_LISTEMPTY, -1, 1'b1);
                    for (int i = 0; i < count; i++)
                        push(srt_pkg::ST_ENTRY, i, i == count - 1);
                end
                srt_pkg::FUNC_ADD: begin
                    if (count >= srt_pkg::Capacity) begin
                        push(srt_pkg::ST_FULL, -1, 1'b1);
                        return;
                    end
                    pos = 0;
                    for (int i = 0; i < count; i++) begin
                        if (keys[i] == key) begin
                            push(srt_pkg::ST_DUP, -1, 1'b1);
                            return;
                        end
                        if (keys[i] < key) pos = i + 1;
                    end
                    for (int i = count; i > pos; i--) begin
                        keys[i] = keys[i-1];
                        names[i] = names[i-1];
                        firms[i] = firms[i-1];
                    end
                    keys[pos] = key;
                    names[pos] = trim(nm);
                    firms[pos] = trim(d[335:184]);
                    count++;
                    push(srt_pkg::ST_ADDED, -1, 1'b1);
                end
                srt_pkg::FUNC_REM: begin
                    if (count == 0) begin
                        push(srt_pkg::ST_EMPTY, -1, 1'b1);
                        return;
                    end
                    hit = find_name(nm);
                    if (hit < 0) begin
                        push(srt_pkg::ST_ABSENT, -1, 1'b1);
                        return;
                    end
                    push(srt_pkg::ST_REMOVED, hit, 1'b1);
                    for (int i = hit; i + 1 < count; i++) begin
                        keys[i] = keys[i+1];
                        names[i] = names[i+1];
                        firms[i] = firms[i+1];
                    end
                    count--;
                end
                default: begin
                    hit = find_name(nm);
                    if (hit < 0) push(srt_pkg::ST_NOTFOUND, -1, 1'b1);
                    else push(srt_pkg::ST_FOUND, hit, 1'b1);
                end
            endcase
        endfunction

        // Compare one field of a result
        function void check_field(input string fname, input logic [63:0] exp,
                                  input logic [63:0] got);
            if (got !== exp) begin
                $error("%s exp %h got %h", fname, exp, got);
                errors++;
            end
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_result(input logic [3:0] st, input logic [335:0] d,
                                   input logic lst);
            t_result e;
            if (pending.size() == 0) begin
                $error("unexpected result status=%0d", st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) begin
                $error("status exp %0d got %0d", e.status, st);
                errors++;
            end
            check_field("out_id", {32'd0, e.data[31:0]}, {32'd0, d[31:0]});
            check_field("out_name0", e.data[95:32], d[95:32]);
            check_field("out_name1", e.data[159:96], d[159:96]);
            check_field("out_name2", {40'd0, e.data[183:160]}, {40'd0, d[183:160]});
            check_field("out_company0", e.data[247:184], d[247:184]);
            check_field("out_company1", e.data[311:248], d[311:248]);
            check_field("out_company2", {40'd0, e.data[335:312]}, {40'd0, d[335:312]});
            if (lst !== e.last) begin
                $error("last exp %0d got %0d", e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [335:0] s_axis_tdata;     // card_id, name 0..2, company 0..2
    logic [1:0]   s_axis_tuser;     // func
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [335:0] m_axis_tdata;     // out_id, out_name0..2, out_company0..2
    logic [3:0]   m_axis_tuser;     // status
    logic         m_axis_tlast;

    record_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    bit  stim_done;
    int  quiet_cycles;

    localparam int WatchdogLimit = 20000;
    localparam int RandWords = (srt_pkg::StrW + 31) / 32;

    sorted_record_table_top uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Small name pool so name searches hit often
    function automatic logic [srt_pkg::StrW-1:0] pick_name(input int k);
        logic [srt_pkg::StrW-1:0] s;
        s = '0;
        case (k % 6)
            0: s[39:0] = "ecila";
            1: s[39:0] = "ECILA";
            2: s[23:0] = "boB";
            3: s[23:0] = "bob";
            4: s[7:0]  = "Z";
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [srt_pkg::StrW-1:0] rand_str();
        logic [RandWords*32-1:0] w;
        for (int i = 0; i < RandWords; i++) w[i*32 +: 32] = $urandom;
        return w[srt_pkg::StrW-1:0];
    endfunction

    // Drive one input transfer, idling first at random
    task automatic send_op(input logic [1:0] fn, input logic signed [31:0] key,
                           input logic [srt_pkg::StrW-1:0] nm,
                           input logic [srt_pkg::StrW-1:0] firm);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {firm, nm, key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_op();
        logic [1:0] fn;
        logic signed [31:0] key;
        logic [srt_pkg::StrW-1:0] nm;
        logic [srt_pkg::StrW-1:0] firm;
        fn = 2'($urandom_range(3));
        if ($urandom_range(3) == 0) fn = srt_pkg::FUNC_ADD;
        key = ($urandom_range(3) == 0) ? $signed($urandom) : $signed($urandom_range(12)) - 6;
        nm = ($urandom_range(3) == 0) ? rand_str() : pick_name($urandom_range(5));
        firm = rand_str();
        send_op(fn, key, nm, firm);
    endtask

    task automatic run_phase(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) random_op();
    endtask

    // Stimulus
    initial begin
        logic [srt_pkg::StrW-1:0] nm;
        sb = new();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = srt_pkg::FUNC_LIST;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty cases, extremes, folding, bytes after a zero, full table
        send_op(srt_pkg::FUNC_LIST, 0, '0, '0);
        send_op(srt_pkg::FUNC_REM, 0, pick_name(0), '0);
        send_op(srt_pkg::FUNC_GET, 0, pick_name(0), '0);
        send_op(srt_pkg::FUNC_ADD, 32'sh7fffffff, pick_name(0), {srt_pkg::StrW{1'b1}});
        send_op(srt_pkg::FUNC_ADD, 32'sh80000000, pick_name(2), '0);
        send_op(srt_pkg::FUNC_ADD, 0, {srt_pkg::StrW{1'b1}}, rand_str());
        send_op(srt_pkg::FUNC_ADD, 0, pick_name(4), '0);
        nm = pick_name(4);
        nm[100 +: 40] = 40'hffeeddccbb;
        send_op(srt_pkg::FUNC_ADD, -1, nm, 152'h0000ff41);
        send_op(srt_pkg::FUNC_GET, 0, pick_name(1), '0);
        send_op(srt_pkg::FUNC_GET, 0, pick_name(4), '0);
        send_op(srt_pkg::FUNC_GET, 0, '0, '0);
        send_op(srt_pkg::FUNC_ADD, 5, '0, '0);
        send_op(srt_pkg::FUNC_ADD, 6, pick_name(3), '0);
        send_op(srt_pkg::FUNC_ADD, 7, rand_str(), rand_str());
        send_op(srt_pkg::FUNC_ADD, 8, rand_str(), rand_str());
        send_op(srt_pkg::FUNC_ADD, 9, rand_str(), rand_str());
        send_op(srt_pkg::FUNC_LIST, 0, '0, '0);
        send_op(srt_pkg::FUNC_REM, 0, pick_name(3), '0);
        send_op(srt_pkg::FUNC_REM, 0, pick_name(5), '0);
        send_op(srt_pkg::FUNC_LIST, 0, '0, '0);

        // Random phases
        run_phase(110, 0, 0);
        run_phase(110, 51, 0);
        run_phase(110, 0, 51);
        // Long receiver hold-off while input keeps coming
        hold_off = 1'b1;
        run_phase(20, 0, 0);
        run_phase(110, 10, 10);
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off
    initial begin
        int held;
        bit hold_done;
        held = 0;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off && !hold_done) begin
                m_axis_tready <= 1'b0;
                held++;
                if (held >= 300) hold_done = 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Monitors: note inputs, check outputs, watchdog and end of run
    initial begin
        int drain;
        quiet_cycles = 0;
        drain = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && s_axis_tvalid && s_axis_tready)
                sb.note_op(s_axis_tuser, s_axis_tdata);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (stim_done && sb.pending.size() == 0) drain++;
            if (drain >= 40) break;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("FAIL");
                $finish;
            end
        end
        if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
